// ----- hw/rtl/hsvrgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

    // Field widths of the input and output transactions.
    localparam int unsigned HUE_W    = 15;
    localparam int unsigned SV_W     = 9;
    localparam int unsigned CH_W     = 8;

    // One 60-degree sector is 3840 hue units, which is 15 * 256.
    localparam int unsigned POS_LO_W    = 8;
    localparam int unsigned HUE_HI_W    = HUE_W - POS_LO_W;
    localparam int unsigned SECTOR_HI   = 15;
    localparam int unsigned SECTOR_W    = 4;
    localparam int unsigned REM_W       = 4;
    localparam int unsigned MAX_SECTORS = 8;
    localparam int unsigned FRAC_W      = 12;
    localparam logic [FRAC_W-1:0] SECTOR_UNITS = 12'd3840;

    // Internal arithmetic widths.
    localparam int unsigned CHROMA_W = 2 * SV_W;
    localparam int unsigned PROD_W   = CHROMA_W + FRAC_W;
    localparam int unsigned SUM_W    = PROD_W + 2;
    localparam int unsigned SCALE_W  = SUM_W + 5;
    localparam int unsigned Q_SHIFT  = 24;
    localparam int unsigned Q_W      = SCALE_W - Q_SHIFT;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SV_W-1:0]  saturation;
        logic [SV_W-1:0]  brightness_value;
    } t_hsv;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // Component order per sector: C = chroma, X = second component, Z = zero,
    // listed as red, green, blue.
    typedef enum logic [2:0] {
        ORD_CXZ = 3'd0,
        ORD_XCZ = 3'd1,
        ORD_ZCX = 3'd2,
        ORD_ZXC = 3'd3,
        ORD_XZC = 3'd4,
        ORD_CZX = 3'd5
    } t_order;

    typedef struct packed {
        t_order              order;
        logic [FRAC_W-1:0]   frac;
        logic [CHROMA_W-1:0] chroma;
        logic [SV_W-1:0]     value;
    } t_stage1;

    // The offset term is two's complement.
    typedef struct packed {
        t_order            order;
        logic [PROD_W-1:0] c_full;
        logic [PROD_W-1:0] x_full;
        logic [PROD_W-1:0] m_full;
    } t_stage2;

    // Channel sums, two's complement.
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_stage3;

    // Sector number from the upper hue bits, by counting passed boundaries.
    function automatic logic [SECTOR_W-1:0] sector_of(input logic [HUE_HI_W-1:0] hi);
        logic [SECTOR_W-1:0] cnt;
        cnt = '0;
        for (int k = 1; k <= MAX_SECTORS; k++) begin
            if (hi >= HUE_HI_W'(SECTOR_HI * k)) begin
                cnt = cnt + SECTOR_W'(1);
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hsvrgb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire hsvrgb_pkg::t_hsv   i_hsv,
    output logic                    o_valid,
    output hsvrgb_pkg::t_stage1     o_stage
);

    logic [hsvrgb_pkg::HUE_HI_W-1:0] hue_hi;
    logic [hsvrgb_pkg::SECTOR_W-1:0] sector;
    logic [hsvrgb_pkg::HUE_HI_W-1:0] rem_hi;
    logic [hsvrgb_pkg::FRAC_W-1:0]   pos;
    hsvrgb_pkg::t_stage1             n_stage;
    hsvrgb_pkg::t_stage1             r_stage;
    logic                            r_valid;

    // Split the hue into sector and position within the sector.
    always_comb begin
        hue_hi = i_hsv.hue[hsvrgb_pkg::HUE_W-1:hsvrgb_pkg::POS_LO_W];
        sector = hsvrgb_pkg::sector_of(hue_hi);
        rem_hi = hue_hi - hsvrgb_pkg::HUE_HI_W'({3'b000, sector}
                 * hsvrgb_pkg::HUE_HI_W'(hsvrgb_pkg::SECTOR_HI));
        pos    = {rem_hi[hsvrgb_pkg::REM_W-1:0], i_hsv.hue[hsvrgb_pkg::POS_LO_W-1:0]};

        n_stage.frac   = sector[0] ? (hsvrgb_pkg::SECTOR_UNITS - pos) : pos;
        n_stage.chroma = hsvrgb_pkg::CHROMA_W'(i_hsv.saturation)
                         * hsvrgb_pkg::CHROMA_W'(i_hsv.brightness_value);
        n_stage.value  = i_hsv.brightness_value;

        // Hues past the last sector keep the last sector's order.
        case (sector)
            4'd0:    n_stage.order = hsvrgb_pkg::ORD_CXZ;
            4'd1:    n_stage.order = hsvrgb_pkg::ORD_XCZ;
            4'd2:    n_stage.order = hsvrgb_pkg::ORD_ZCX;
            4'd3:    n_stage.order = hsvrgb_pkg::ORD_ZXC;
            4'd4:    n_stage.order = hsvrgb_pkg::ORD_XZC;
            default: n_stage.order = hsvrgb_pkg::ORD_CZX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_scale (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire hsvrgb_pkg::t_stage1  i_stage,
    output logic                      o_valid,
    output hsvrgb_pkg::t_stage2       o_stage
);

    logic [hsvrgb_pkg::PROD_W-1:0]   chroma_ext;
    logic [hsvrgb_pkg::CHROMA_W-1:0] offset;
    logic [hsvrgb_pkg::PROD_W-1:0]   offset_ext;
    hsvrgb_pkg::t_stage2             n_stage;
    hsvrgb_pkg::t_stage2             r_stage;
    logic                            r_valid;

    // Scaling by 3840 is (v << 12) - (v << 8).
    always_comb begin
        chroma_ext = hsvrgb_pkg::PROD_W'(i_stage.chroma);
        offset     = {1'b0, i_stage.value, 8'h00} - i_stage.chroma;
        offset_ext = {{(hsvrgb_pkg::PROD_W - hsvrgb_pkg::CHROMA_W){offset[hsvrgb_pkg::CHROMA_W-1]}},
                      offset};

        n_stage.order  = i_stage.order;
        n_stage.c_full = (chroma_ext << 12) - (chroma_ext << 8);
        n_stage.x_full = chroma_ext * hsvrgb_pkg::PROD_W'(i_stage.frac);
        n_stage.m_full = (offset_ext << 12) - (offset_ext << 8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_mix (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire hsvrgb_pkg::t_stage2  i_stage,
    output logic                      o_valid,
    output hsvrgb_pkg::t_stage3       o_stage
);

    logic [hsvrgb_pkg::SUM_W-1:0] c_ext;
    logic [hsvrgb_pkg::SUM_W-1:0] x_ext;
    logic [hsvrgb_pkg::SUM_W-1:0] m_ext;
    logic [hsvrgb_pkg::SUM_W-1:0] cm;
    logic [hsvrgb_pkg::SUM_W-1:0] xm;
    hsvrgb_pkg::t_stage3          n_stage;
    hsvrgb_pkg::t_stage3          r_stage;
    logic                         r_valid;

    always_comb begin
        c_ext = hsvrgb_pkg::SUM_W'(i_stage.c_full);
        x_ext = hsvrgb_pkg::SUM_W'(i_stage.x_full);
        m_ext = {{(hsvrgb_pkg::SUM_W - hsvrgb_pkg::PROD_W){i_stage.m_full[hsvrgb_pkg::PROD_W-1]}},
                 i_stage.m_full};
        cm = c_ext + m_ext;
        xm = x_ext + m_ext;

        case (i_stage.order)
            hsvrgb_pkg::ORD_CXZ: begin
                n_stage = '{red: cm, green: xm, blue: m_ext};
            end
            hsvrgb_pkg::ORD_XCZ: begin
                n_stage = '{red: xm, green: cm, blue: m_ext};
            end
            hsvrgb_pkg::ORD_ZCX: begin
                n_stage = '{red: m_ext, green: cm, blue: xm};
            end
            hsvrgb_pkg::ORD_ZXC: begin
                n_stage = '{red: m_ext, green: xm, blue: cm};
            end
            hsvrgb_pkg::ORD_XZC: begin
                n_stage = '{red: xm, green: m_ext, blue: cm};
            end
            default: begin
                n_stage = '{red: cm, green: m_ext, blue: xm};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_quant.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_quant (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire hsvrgb_pkg::t_stage3  i_stage,
    output logic                      o_valid,
    output hsvrgb_pkg::t_rgb          o_rgb
);

    hsvrgb_pkg::t_rgb n_rgb;
    hsvrgb_pkg::t_rgb r_rgb;
    logic             r_valid;

    // The full-scale divisor is 15 * 2^24 and 255 / 15 = 17, so a channel is
    // (17 * sum) >> 24, zero for sums that are not positive, clamped at 255.
    function automatic logic [hsvrgb_pkg::CH_W-1:0] to_channel(
        input logic [hsvrgb_pkg::SUM_W-1:0] sum
    );
        logic [hsvrgb_pkg::SCALE_W-1:0] sum_ext;
        logic [hsvrgb_pkg::SCALE_W-1:0] scaled;
        logic [hsvrgb_pkg::Q_W-1:0]     q;
        logic [hsvrgb_pkg::CH_W-1:0]    ch;
        sum_ext = {{(hsvrgb_pkg::SCALE_W - hsvrgb_pkg::SUM_W){sum[hsvrgb_pkg::SUM_W-1]}}, sum};
        scaled  = (sum_ext << 4) + sum_ext;
        q       = scaled[hsvrgb_pkg::SCALE_W-1:hsvrgb_pkg::Q_SHIFT];
        if (sum[hsvrgb_pkg::SUM_W-1] || (sum == '0)) begin
            ch = '0;
        end else if (q > hsvrgb_pkg::Q_W'(hsvrgb_pkg::CH_MAX)) begin
            ch = hsvrgb_pkg::CH_MAX;
        end else begin
            ch = q[hsvrgb_pkg::CH_W-1:0];
        end
        return ch;
    endfunction

    always_comb begin
        n_rgb.red   = to_channel(i_stage.red);
        n_rgb.green = to_channel(i_stage.green);
        n_rgb.blue  = to_channel(i_stage.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_converter_core.sv -----
// HSV to RGB converter core.
// Input channel: i_valid, i_hsv (hue in 1/64 degree, saturation and value in
// unsigned Q1.8) and o_stall. A transaction is taken at a rising clock edge
// where i_valid is high and o_stall is low.
// Output channel: o_valid, o_rgb (8-bit red, green, blue) and i_stall. A
// transaction is delivered at an edge where o_valid is high and i_stall is low.
// Every input transaction produces exactly one output transaction.
// The datapath is a four-stage pipeline: sector decode and chroma multiply,
// component scaling with the chroma-by-fraction multiply, channel summing,
// and the final scale-and-clamp into the output register. An accepted
// transaction passes the front, scale, mix and quant registers in that order
// before o_valid rises, and throughput is one transaction per cycle while
// the receiver does not stall.
// Each stage advances when its register is empty or the next stage advances,
// so empty slots close up and a stall stops only the stages behind a full one.
// While the receiver stalls with the pipeline full, o_stall rises and the
// held result stays on o_rgb unchanged.
// Reset is synchronous and active low; it empties the pipeline and no output
// transaction appears until new input arrives.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire hsvrgb_pkg::t_hsv  i_hsv,
    output logic                   o_stall,
    output logic                   o_valid,
    output hsvrgb_pkg::t_rgb       o_rgb,
    input  wire logic              i_stall
);

    logic                v1;
    logic                v2;
    logic                v3;
    logic                v4;
    logic                en1;
    logic                en2;
    logic                en3;
    logic                en4;
    hsvrgb_pkg::t_stage1 s1;
    hsvrgb_pkg::t_stage2 s2;
    hsvrgb_pkg::t_stage3 s3;

    // A stage may load when it holds nothing or when its contents move on.
    assign en4 = !v4 || !i_stall;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;

    assign o_stall = !en1;
    assign o_valid = v4;

    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_valid (i_valid),
        .i_hsv   (i_hsv),
        .o_valid (v1),
        .o_stage (s1)
    );

    hsvrgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (v1),
        .i_stage (s1),
        .o_valid (v2),
        .o_stage (s2)
    );

    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_valid (v2),
        .i_stage (s2),
        .o_valid (v3),
        .o_stage (s3)
    );

    hsvrgb_quant u_quant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en4),
        .i_valid (v3),
        .i_stage (s3),
        .o_valid (v4),
        .o_rgb   (o_rgb)
    );

`ifndef SYNTHESIS
    // Reset empties the output stage.
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Back pressure appears only when every stage holds a transaction.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (v1 && v2 && v3 && v4 && i_stall))
        else $error("input stalled with room in the pipeline");

    // With the receiver taking data the input is never stalled.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output flows");

    // A result in the last internal stage reaches the output on an advance.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v3 && en4) |=> o_valid)
        else $error("transaction lost between mix and output stage");
`endif

endmodule

`default_nettype wire

// ----- test/tb_hsv_to_rgb_converter_core.sv -----
`timescale 1ns / 1ps

// Testbench for the HSV to RGB converter core.
// A queue of pixel transactions is filled up front: a short directed set that
// hits every sector boundary, the field extremes, negative offsets, clamping
// and hues past 360 degrees, followed by random pixels. A falling-edge driver
// feeds the queue into the block, and a rising-edge monitor predicts each
// accepted pixel and checks every delivered result against the oldest
// prediction in order.
module tb_hsv_to_rgb_converter_core;

    localparam int    CLK_PERIOD   = 8;
    localparam int    RANDOM_ITEMS = 1600;
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    MAX_REPORTS  = 10;
    localparam int    DRAIN_CYCLES = 12;
    localparam int    HUE_IN_RANGE = 23039;
    localparam int    UNIT_ONE     = 256;

    // One 60-degree sector in hue units, and the denominator that brings a
    // channel sum back to full scale (chroma units times sector units).
    localparam longint SECTOR_SPAN = longint'(hsvrgb_pkg::SECTOR_UNITS);
    localparam longint FULL_SCALE  = 64'd65536 * SECTOR_SPAN;
    localparam longint HUE_WRAP    = 6 * SECTOR_SPAN;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    hsvrgb_pkg::t_hsv i_hsv   = '0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    hsvrgb_pkg::t_rgb o_rgb;

    hsv_to_rgb_converter_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_hsv   (i_hsv),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_rgb   (o_rgb),
        .i_stall (i_stall)
    );

    // Pixels waiting to be driven, and colors the block still owes us.
    hsvrgb_pkg::t_hsv hsv_pending_q[$];
    hsvrgb_pkg::t_rgb rgb_expected_q[$];

    int  total_pixels     = 0;
    int  pixels_driven    = 0;
    int  pixels_checked   = 0;
    int  wide_hue_pixels  = 0;
    int  error_count      = 0;
    int  cycle_count      = 0;
    int  send_idle_pct    = 0;
    int  recv_idle_pct    = 0;
    bit  input_taken      = 1'b0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Turns one channel sum (in units of 1/FULL_SCALE) into an 8-bit intensity.
    // Sums at or below zero read as black; negative ones come from a negative offset.
    function automatic logic [hsvrgb_pkg::CH_W-1:0] to_intensity(input longint sum);
        longint q;
        if (sum <= 0) begin
            return '0;
        end
        q = (sum * 255) / FULL_SCALE;
        return (q > 255) ? hsvrgb_pkg::CH_MAX : q[hsvrgb_pkg::CH_W-1:0];
    endfunction

    // Exact fixed-point conversion of one pixel. Every component is carried
    // in units of 1/(65536 * 3840) so no precision is lost before the floor.
    function automatic hsvrgb_pkg::t_rgb convert_hsv(input hsvrgb_pkg::t_hsv px);
        longint             sector;
        longint             pos;
        longint             frac;
        longint             chroma;
        longint             c_term;
        longint             x_term;
        longint             m_term;
        longint             r_sum;
        longint             g_sum;
        longint             b_sum;
        hsvrgb_pkg::t_order order;
        hsvrgb_pkg::t_rgb   res;
        sector = longint'(px.hue) / SECTOR_SPAN;
        pos    = longint'(px.hue) % SECTOR_SPAN;
        // Odd sectors fall away from the boundary, even ones rise toward it.
        frac   = (sector % 2 == 1) ? (SECTOR_SPAN - pos) : pos;
        chroma = longint'(px.saturation) * longint'(px.brightness_value);
        c_term = chroma * SECTOR_SPAN;
        x_term = chroma * frac;
        // The offset goes negative whenever saturation exceeds 1.0 and value is not zero.
        m_term = (longint'(px.brightness_value) * UNIT_ONE - chroma) * SECTOR_SPAN;
        // Hues past the last sector keep the last sector's component order.
        order  = (sector > 5) ? hsvrgb_pkg::ORD_CZX : hsvrgb_pkg::t_order'(sector[2:0]);
        case (order)
            hsvrgb_pkg::ORD_CXZ: begin
                r_sum = c_term; g_sum = x_term; b_sum = 0;
            end
            hsvrgb_pkg::ORD_XCZ: begin
                r_sum = x_term; g_sum = c_term; b_sum = 0;
            end
            hsvrgb_pkg::ORD_ZCX: begin
                r_sum = 0; g_sum = c_term; b_sum = x_term;
            end
            hsvrgb_pkg::ORD_ZXC: begin
                r_sum = 0; g_sum = x_term; b_sum = c_term;
            end
            hsvrgb_pkg::ORD_XZC: begin
                r_sum = x_term; g_sum = 0; b_sum = c_term;
            end
            default: begin
                r_sum = c_term; g_sum = 0; b_sum = x_term;
            end
        endcase
        res.red   = to_intensity(r_sum + m_term);
        res.green = to_intensity(g_sum + m_term);
        res.blue  = to_intensity(b_sum + m_term);
        return res;
    endfunction

    function automatic hsvrgb_pkg::t_hsv make_hsv(input int hue, input int sat,
                                                  input int val);
        hsvrgb_pkg::t_hsv px;
        px.hue              = hue[hsvrgb_pkg::HUE_W-1:0];
        px.saturation       = sat[hsvrgb_pkg::SV_W-1:0];
        px.brightness_value = val[hsvrgb_pkg::SV_W-1:0];
        return px;
    endfunction

    // Stimulus: the directed pixels, then random ones. Most random pixels stay
    // inside the documented ranges; the rest use every bit of every field so
    // that hues past 360 degrees and saturation or value above 1.0 show up.
    task automatic queue_pixels();
        int sat;
        int val;
        int hue;
        // Pure primaries and the six sector boundaries at full color.
        hsv_pending_q.push_back(make_hsv(0, 256, 256));
        hsv_pending_q.push_back(make_hsv(3839, 256, 256));
        hsv_pending_q.push_back(make_hsv(3840, 256, 256));
        hsv_pending_q.push_back(make_hsv(7680, 256, 256));
        hsv_pending_q.push_back(make_hsv(11520, 256, 256));
        hsv_pending_q.push_back(make_hsv(15360, 256, 256));
        hsv_pending_q.push_back(make_hsv(19200, 256, 256));
        hsv_pending_q.push_back(make_hsv(HUE_IN_RANGE, 256, 256));
        // Hues beyond the last sector, up to the all-ones hue.
        hsv_pending_q.push_back(make_hsv(int'(HUE_WRAP), 256, 256));
        hsv_pending_q.push_back(make_hsv(27000, 200, 200));
        hsv_pending_q.push_back(make_hsv(32767, 511, 511));
        hsv_pending_q.push_back(make_hsv(32767, 0, 0));
        // Black, gray and dark corners.
        hsv_pending_q.push_back(make_hsv(0, 0, 0));
        hsv_pending_q.push_back(make_hsv(1920, 0, 256));
        hsv_pending_q.push_back(make_hsv(5000, 256, 0));
        hsv_pending_q.push_back(make_hsv(17000, 511, 0));
        hsv_pending_q.push_back(make_hsv(21000, 1, 1));
        // Saturation above 1.0 drives the offset negative.
        hsv_pending_q.push_back(make_hsv(9000, 511, 256));
        hsv_pending_q.push_back(make_hsv(13000, 300, 128));
        // Value above 1.0 pushes channels into the clamp.
        hsv_pending_q.push_back(make_hsv(14000, 300, 511));
        hsv_pending_q.push_back(make_hsv(0, 256, 511));
        hsv_pending_q.push_back(make_hsv(1920, 0, 511));
        hsv_pending_q.push_back(make_hsv(12345, 128, 128));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(9) < 8) begin
                hue = $urandom_range(HUE_IN_RANGE);
                sat = $urandom_range(UNIT_ONE);
                val = $urandom_range(UNIT_ONE);
            end else begin
                hue = $urandom_range((1 << hsvrgb_pkg::HUE_W) - 1);
                sat = $urandom_range((1 << hsvrgb_pkg::SV_W) - 1);
                val = $urandom_range((1 << hsvrgb_pkg::SV_W) - 1);
            end
            hsv_pending_q.push_back(make_hsv(hue, sat, val));
        end
        total_pixels = hsv_pending_q.size();
    endtask

    // Driver. Inputs move on the falling edge. A new pixel is presented only
    // once the current one has been taken, so a stalled payload holds steady.
    // The idling mix follows the progress through the queue: first a mostly
    // busy sender against a reluctant receiver, then the reverse, and at the
    // end both sides run flat out.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pixels_driven < total_pixels / 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 63;
            end else if (pixels_driven < (2 * total_pixels) / 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (!i_valid || input_taken) begin
                if (hsv_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_hsv   <= hsv_pending_q.pop_front();
                    i_valid <= 1'b1;
                    pixels_driven++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor. Both channels are sampled on the rising edge. A delivered
    // color is checked before the pixel taken on the same edge is predicted,
    // so a result can never be matched against its own input.
    always @(posedge i_clk) begin : monitor
        hsvrgb_pkg::t_rgb want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (rgb_expected_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("ERROR: unexpected transaction r=%0d g=%0d b=%0d",
                                 o_rgb.red, o_rgb.green, o_rgb.blue);
                    end
                end else begin
                    want = rgb_expected_q.pop_front();
                    pixels_checked++;
                    if (o_rgb.red !== want.red || o_rgb.green !== want.green ||
                        o_rgb.blue !== want.blue) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display({"ERROR: result %0d expected r=%0d g=%0d b=%0d, ",
                                      "got r=%0d g=%0d b=%0d"},
                                     pixels_checked, want.red, want.green, want.blue,
                                     o_rgb.red, o_rgb.green, o_rgb.blue);
                        end
                    end
                end
            end
            input_taken = i_valid && !o_stall;
            if (input_taken) begin
                rgb_expected_q.push_back(convert_hsv(i_hsv));
                if (i_hsv.hue > HUE_IN_RANGE) begin
                    wide_hue_pixels++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, rgb_expected_q.size());
            $display("tb_hsv_to_rgb_converter_core failed");
            $finish;
        end
    end

    initial begin
        queue_pixels();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Wait until every pixel has been taken and every color delivered.
        while (hsv_pending_q.size() > 0 || i_valid || rgb_expected_q.size() > 0) begin
            @(posedge i_clk);
        end
        // Give the pipeline a few more cycles to show any stray transaction.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Converted %0d pixels (%0d with hues past 360 degrees)",
                 pixels_checked, wide_hue_pixels);
        $display("under three idling mixes; mismatches or stray results: %0d",
                 error_count);
        if (error_count == 0 && rgb_expected_q.size() == 0) begin
            $display("tb_hsv_to_rgb_converter_core passed");
        end else begin
            $display("tb_hsv_to_rgb_converter_core failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_front.sv
hw/rtl/hsvrgb_scale.sv
hw/rtl/hsvrgb_mix.sv
hw/rtl/hsvrgb_quant.sv
hw/rtl/hsv_to_rgb_converter_core.sv
test/tb_hsv_to_rgb_converter_core.sv
